// ===== hw/rtl/ctli_pkg.sv =====
// shared types and constants for the curve table interpolator
package ctli_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd2;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_BAD,
        OP_ZERO,
        OP_ENTRY,
        OP_BLEND
    } op_kind_t;

    typedef struct packed {
        op_kind_t     kind;
        logic [31:0]  value;
        logic [15:0]  frac;
    } op_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic [31:0]        ratio;
        logic [8:0]         size_in_use;
    } cfg_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIFF,
        FE_MUL,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_DELTA,
        BE_MUL,
        BE_SUM,
        BE_OUT
    } be_state_t;

endpackage

// ===== hw/rtl/ctli_front.sv =====
// front end: takes beats, forms the table position and classifies each item
module ctli_front #(
    parameter int TABLE_DEPTH = ctli_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctli_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [7:0]          entry_index,
    input  logic signed [31:0]  entry_value,
    input  logic signed [31:0]  x_in,
    output logic                q_push,
    input  logic                q_full,
    output ctli_pkg::op_t       q_op,
    output logic [IDX_W-1:0]    q_addr
);
    import ctli_pkg::*;

    localparam int SZ_W = $clog2(TABLE_DEPTH + 1);

    fe_state_t          state_reg;
    fe_state_t          state_next;
    logic               mode_reg;
    logic [7:0]         index_reg;
    logic [31:0]        value_reg;
    logic [31:0]        x_reg;
    logic [31:0]        diff_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [32:0]        diff_w;
    logic [63:0]        prod_w;
    logic [SZ_W-1:0]    n_eff;
    logic [31:0]        n_m1;
    logic               in_fire;

    assign in_fire = in_valid && !in_stall;
    assign diff_w  = {x_reg[31], x_reg} - {cfg.min_x[31], cfg.min_x};
    assign prod_w  = diff_reg * cfg.ratio;

    always_comb
    begin
        if (32'(cfg.size_in_use) > 32'(TABLE_DEPTH))
        begin
            n_eff = SZ_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = SZ_W'(cfg.size_in_use);
        end
        n_m1 = 32'(n_eff) - 32'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FE_IDLE: if (in_valid) state_next = FE_DIFF;
            FE_DIFF: state_next = FE_MUL;
            FE_MUL:  state_next = FE_PUSH;
            FE_PUSH: if (!q_full) state_next = FE_IDLE;
            default: state_next = FE_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != FE_IDLE);
        q_push   = (state_reg == FE_PUSH) && !q_full;
    end

    // classification
    always_comb
    begin
        q_op.value = value_reg;
        q_op.frac  = prod_reg[31:16];
        q_addr     = '0;
        if (!mode_reg)
        begin
            q_addr = IDX_W'(index_reg);
            if (32'(index_reg) >= 32'(n_eff))
            begin
                q_op.kind = OP_BAD;
            end
            else
            begin
                q_op.kind = OP_WRITE;
            end
        end
        else
        begin
            priority if (n_eff == '0)
            begin
                q_op.kind = OP_ZERO;
            end
            else if (neg_reg)
            begin
                q_op.kind = OP_ENTRY;
            end
            else if (prod_reg[63:32] >= n_m1)
            begin
                q_op.kind = OP_ENTRY;
                q_addr    = IDX_W'(n_m1);
            end
            else
            begin
                q_op.kind = OP_BLEND;
                q_addr    = IDX_W'(prod_reg[63:32]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= mode;
            index_reg <= entry_index;
            value_reg <= entry_value;
            x_reg     <= x_in;
        end
        if (state_reg == FE_DIFF)
        begin
            neg_reg  <= diff_w[32];
            diff_reg <= diff_w[32] ? 32'd0 : diff_w[31:0];
        end
        if (state_reg == FE_MUL)
        begin
            prod_reg <= prod_w;
        end
    end

    a_push_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full && !in_stall == 1'b0)
        else $error("front pushed without room");

endmodule

// ===== hw/rtl/ctli_queue.sv =====
// short fifo between front and back ends
module ctli_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ctli_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [W-1:0]  push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output logic [W-1:0]  head
);
    import ctli_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]      slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

endmodule

// ===== hw/rtl/ctli_back.sv =====
// back end: sample table, blend arithmetic and result register
module ctli_back #(
    parameter int TABLE_DEPTH = ctli_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ctli_pkg::op_t       q_op,
    input  logic [IDX_W-1:0]    q_addr,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  y_out,
    output logic                bad_index
);
    import ctli_pkg::*;

    be_state_t           state_reg;
    be_state_t           state_next;
    logic [31:0]         mem [TABLE_DEPTH];
    logic [31:0]         rd_a_reg;
    logic [31:0]         rd_b_reg;
    op_kind_t            kind_reg;
    logic [15:0]         frac_reg;
    logic signed [32:0]  delta_reg;
    logic signed [49:0]  blend_reg;
    logic [31:0]         y_reg;
    logic                bad_reg;
    logic [IDX_W-1:0]    addr_p1;
    logic signed [32:0]  delta_w;
    logic [31:0]         sum_w;

    assign addr_p1 = q_addr + IDX_W'(1);
    assign delta_w = $signed({rd_b_reg[31], rd_b_reg}) - $signed({rd_a_reg[31], rd_a_reg});
    assign sum_w   = rd_a_reg + blend_reg[47:16];
    assign y_out     = y_reg;
    assign bad_index = bad_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BE_IDLE:  if (q_valid) state_next = BE_DELTA;
            BE_DELTA: state_next = BE_MUL;
            BE_MUL:   state_next = BE_SUM;
            BE_SUM:   state_next = BE_OUT;
            BE_OUT:   if (!out_stall) state_next = BE_IDLE;
            default:  state_next = BE_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == BE_IDLE) && q_valid;
        out_valid = (state_reg == BE_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // table port
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_op.kind == OP_WRITE)
            begin
                mem[q_addr] <= q_op.value;
            end
            rd_a_reg <= mem[q_addr];
            rd_b_reg <= mem[addr_p1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg <= q_op.kind;
            frac_reg <= q_op.frac;
        end
        if (state_reg == BE_DELTA)
        begin
            delta_reg <= delta_w;
        end
        if (state_reg == BE_MUL)
        begin
            blend_reg <= delta_reg * $signed({1'b0, frac_reg});
        end
        if (state_reg == BE_SUM)
        begin
            unique case (kind_reg)
                OP_BAD:
                begin
                    y_reg   <= 32'd0;
                    bad_reg <= 1'b1;
                end
                OP_ENTRY:
                begin
                    y_reg   <= rd_a_reg;
                    bad_reg <= 1'b0;
                end
                OP_BLEND:
                begin
                    y_reg   <= sum_w;
                    bad_reg <= 1'b0;
                end
                default:
                begin
                    y_reg   <= 32'd0;
                    bad_reg <= 1'b0;
                end
            endcase
        end
    end

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> y_out == 32'sd0)
        else $error("flagged write carries a value");

    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == BE_DELTA)
        else $error("pop did not start the back end");

endmodule

// ===== hw/rtl/curve_table_linear_interp.sv =====
// top level of the curve table interpolator: config registers, front, queue, back
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  in       | in_valid / in_stall   | mode, entry_index, entry_value, x_in
//  out      | out_valid / out_stall | y_out, bad_index
//  cfg      | cfg_we                | cfg_index, cfg_data
//
//  the front takes one beat at a time and stalls the input until it has pushed that beat
//  into the queue; the back sequencer (table read, difference, blend multiply, sum) takes
//  a new item only once the last result has been taken at out; a result passes the front
//  states, the queue and the back states before it is offered at out
//  a 2-entry queue between front and back lets the front keep taking beats, until the
//  queue fills, while a result waits on out_stall
//  rst_n clears the config registers and all control state; table contents stay undefined
module curve_table_linear_interp #(
    parameter int TABLE_DEPTH = ctli_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ctli_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [7:0]                     entry_index,
    input  logic signed [31:0]             entry_value,
    input  logic signed [31:0]             x_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             y_out,
    output logic                           bad_index
);
    import ctli_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int Q_W   = $bits(op_t) + IDX_W;

    cfg_t              cfg_reg;
    op_t               fe_op;
    logic [IDX_W-1:0]  fe_addr;
    logic              fe_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [Q_W-1:0]    q_head;
    op_t               be_op;
    logic [IDX_W-1:0]  be_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_X: cfg_reg.min_x       <= cfg_data;
                CFG_RATIO: cfg_reg.ratio       <= cfg_data;
                CFG_SIZE:  cfg_reg.size_in_use <= cfg_data[8:0];
                default:   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    ctli_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .x_in        (x_in),
        .q_push      (fe_push),
        .q_full      (q_full),
        .q_op        (fe_op),
        .q_addr      (fe_addr)
    );

    ctli_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_data ({fe_op, fe_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    assign be_op   = q_head[Q_W-1:IDX_W];
    assign be_addr = q_head[IDX_W-1:0];

    ctli_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (be_op),
        .q_addr    (be_addr),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .y_out     (y_out),
        .bad_index (bad_index)
    );

endmodule

// ===== verif/ctli_checker.sv =====
// stimulus codes shared by the bench, and the checker that predicts and compares interpolator results
`timescale 1ns / 1ps

package ctli_tb_pkg;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [ctli_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

endpackage

module ctli_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ctli_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           mode,
    input  logic [7:0]                     entry_index,
    input  logic signed [31:0]             entry_value,
    input  logic signed [31:0]             x_in,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [31:0]             y_out,
    input  logic                           bad_index,
    output int                             fail_count,
    output int                             pending
);
    import ctli_pkg::*;
    import ctli_tb_pkg::*;

    typedef struct packed {
        logic [31:0] y;
        logic        bad;
    } curve_result_t;

    logic signed [31:0] cur_min_x;
    logic [31:0]        cur_ratio;
    logic [8:0]         cur_size;
    logic [31:0]        samples [TABLE_DEPTH_DEF];
    curve_result_t      awaited [$];

    function automatic int unsigned live_entries();
        return (cur_size > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cur_size;
    endfunction

    function automatic logic signed [31:0] blend_curve(input logic signed [31:0] x);
        int unsigned n;
        longint      span;
        logic [63:0] pos;
        int unsigned seg;
        logic [15:0] w;
        longint      lo;
        longint      hi;
        longint      acc;
        n = live_entries();
        if (n == 0)
            return '0;
        span = longint'(x) - longint'(cur_min_x);
        if (span < 0)
        begin
            if (cur_ratio != 0)
                return samples[0];
            span = 0;
        end
        pos = {32'd0, span[31:0]} * {32'd0, cur_ratio};
        if (pos[63:32] >= n - 1)
            return samples[n-1];
        seg = pos[63:32];
        w   = pos[31:16];
        lo  = longint'($signed(samples[seg]));
        hi  = longint'($signed(samples[seg+1]));
        acc = lo * (longint'(65536) - longint'(w)) + hi * longint'(w);
        return 32'(acc >>> 16);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        curve_result_t head;
        curve_result_t fresh;
        if (!rst_n)
        begin
            cur_min_x  = '0;
            cur_ratio  = '0;
            cur_size   = '0;
            fail_count = 0;
            awaited.delete();
            pending   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $error("y_out: expected no beat, actual %h", y_out);
                    fail_count++;
                end
                else
                begin
                    head = awaited.pop_front();
                    if (y_out !== head.y)
                    begin
                        $error("y_out: expected %h, actual %h", head.y, y_out);
                        fail_count++;
                    end
                    if (bad_index !== head.bad)
                    begin
                        $error("bad_index: expected %b, actual %b", head.bad, bad_index);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_X: cur_min_x = cfg_data;
                    CFG_RATIO: cur_ratio = cfg_data;
                    CFG_SIZE:  cur_size  = cfg_data[8:0];
                    default:   ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_WRITE)
                begin
                    fresh.y   = '0;
                    fresh.bad = (entry_index >= live_entries());
                    if (!fresh.bad)
                        samples[entry_index] = entry_value;
                end
                else
                begin
                    fresh.y   = blend_curve(x_in);
                    fresh.bad = 1'b0;
                end
                awaited.push_back(fresh);
            end
            pending <= awaited.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// top of the interpolator bench: clock, reset, config phases, sample and lookup traffic, verdict
`timescale 1ns / 1ps

module tb;
    import ctli_pkg::*;
    import ctli_tb_pkg::*;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_MIN_X;
    logic [31:0]          cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic                 mode        = MODE_READ;
    logic [7:0]           entry_index = '0;
    logic signed [31:0]   entry_value = '0;
    logic signed [31:0]   x_in        = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic signed [31:0]   y_out;
    logic                 bad_index;
    int                   fail_count;
    int                   pending;

    int          send_gap_pct   = 19;
    int          recv_stall_pct = 77;
    logic [31:0] cur_min_x      = '0;
    logic [31:0] cur_ratio      = '0;
    int unsigned live_size      = 0;
    bit          written [256];

    logic [31:0] phase_min_x [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF0_0000, 32'h0000_0000,
                                     32'h0005_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000};
    logic [31:0] phase_ratio [8] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0004_0000, 32'h0000_0000,
                                     32'h0000_8000, 32'h0000_1000, 32'h0000_0000, 32'h0001_0000};
    logic [8:0]  phase_size  [8] = '{9'd256, 9'd1, 9'd16, 9'd8, 9'd300, 9'd2, 9'd0, 9'd0};

    always #1 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    curve_table_linear_interp u_dut (.*);

    ctli_checker u_check (.*);

    task automatic push_beat(input logic m, input logic [7:0] idx, input logic [31:0] val,
                             input logic [31:0] x);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        entry_index <= idx;
        entry_value <= val;
        x_in        <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_sample(input logic [7:0] idx, input logic [31:0] val);
        push_beat(MODE_WRITE, idx, val, $urandom);
        if (idx < live_size)
            written[idx] = 1'b1;
    endtask

    task automatic read_curve_at(input logic [31:0] x);
        push_beat(MODE_READ, 8'($urandom), $urandom, x);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_curve(input logic [31:0] mx, input logic [31:0] rt,
                                 input logic [8:0] sz);
        settle();
        cfg_write(CFG_UNUSED, $urandom);
        cfg_write(CFG_MIN_X, mx);
        cfg_write(CFG_RATIO, rt);
        cfg_write(CFG_SIZE, {23'd0, sz});
        cfg_we    <= 1'b0;
        cur_min_x = mx;
        cur_ratio = rt;
        live_size = (sz > 256) ? 256 : sz;
    endtask

    task automatic fill_missing();
        for (int i = 0; i < live_size; i++)
            if (!written[i])
                write_sample(8'(i), $urandom);
    endtask

    task automatic random_traffic(input int count);
        logic [63:0] reach;
        logic [63:0] off;
        int          pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                if (live_size != 0 && $urandom_range(0, 4) != 0)
                    write_sample(8'($urandom_range(0, live_size - 1)), $urandom);
                else
                    write_sample(8'($urandom), $urandom);
            end
            else if (pick < 72 && cur_ratio != 0 && live_size != 0)
            begin
                reach = ({32'd0, live_size} << 32) / {32'd0, cur_ratio};
                off   = {$urandom, $urandom} % (reach + (reach >> 3) + 64'd2);
                read_curve_at(cur_min_x + off[31:0]);
            end
            else if (pick < 82)
                read_curve_at(cur_min_x - $urandom_range(1, 32'h0003_0000));
            else
                read_curve_at($urandom);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no curve loaded
        read_curve_at(32'h0000_0000);
        read_curve_at(32'h8000_0000);
        write_sample(8'd0, 32'h1234_5678);

        program_curve(32'h0000_0000, 32'h0001_0000, 9'd4);
        write_sample(8'd0, 32'h8000_0000);
        write_sample(8'd1, 32'h7FFF_FFFF);
        write_sample(8'd2, 32'h0000_0000);
        write_sample(8'd3, 32'hFFFF_FFFF);
        write_sample(8'd4, $urandom);
        write_sample(8'd255, $urandom);
        read_curve_at(32'hFFFF_FFFF);
        read_curve_at(32'h0000_0000);
        read_curve_at(32'h0000_8000);
        read_curve_at(32'h0001_FFFF);
        read_curve_at(32'h0002_C000);
        read_curve_at(32'h0003_0000);
        read_curve_at(32'h7FFF_FFFF);
        read_curve_at(32'h8000_0000);

        for (int p = 0; p < 8; p++)
        begin
            if (p == 2)
            begin
                send_gap_pct   = 77;
                recv_stall_pct = 19;
            end
            if (p == 5)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            if (p == 6)
                program_curve($urandom, $urandom >> $urandom_range(0, 24),
                              9'($urandom_range(2, 256)));
            else
                program_curve(phase_min_x[p], phase_ratio[p], phase_size[p]);
            fill_missing();
            random_traffic(30);
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("curve_table_linear_interp: match");
        else
            $display("curve_table_linear_interp: mismatch");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("curve_table_linear_interp: mismatch");
        $finish;
    end

endmodule

// ===== curve_table_linear_interp.f =====
hw/rtl/ctli_pkg.sv
hw/rtl/ctli_front.sv
hw/rtl/ctli_queue.sv
hw/rtl/ctli_back.sv
hw/rtl/curve_table_linear_interp.sv
verif/ctli_checker.sv
verif/tb.sv
